FILE: rtl/kv_record_stream_walker_top_macros.svh
// ----------------------------------------------------------------------------
// kv_record_stream_walker_top_macros.svh
// Assertion macros used by the record walker top level.
// ----------------------------------------------------------------------------
`ifndef KV_RECORD_STREAM_WALKER_TOP_MACROS_SVH
`define KV_RECORD_STREAM_WALKER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KVW_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KVW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/kvw_pkg.sv
// ----------------------------------------------------------------------------
// kvw_pkg
// Shared constants and types of the key/value record walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvw_pkg;

	localparam int LENGTH_BITS  = 26;
	localparam int FLAG_BIT     = 31;
	localparam int OFFSET_BITS  = 24;
	localparam int KEY_BITS     = 16;
	localparam int COUNT_BITS   = 16;
	localparam int CNT_BITS     = 16;

	localparam int HDR_BYTES    = 4;
	localparam int KEYLEN_BYTES = 2;
	localparam int MIN_OVERHEAD = 8;

	// header byte (0 = first) and bit within it that carry the flag
	localparam int FLAG_BYTE    = (31 - FLAG_BIT) / 8;
	localparam int FLAG_POS     = FLAG_BIT % 8;

	localparam int CMP_BITS     = ((LENGTH_BITS > KEY_BITS) ? LENGTH_BITS : KEY_BITS) + 1;

	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		KIND_DESC = 2'd0,
		KIND_OK   = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_OVER  = 2'd1;
	localparam logic [1:0] ERR_SHORT = 2'd2;
	localparam logic [1:0] ERR_TERM  = 2'd3;

	typedef struct packed {
		kind_t                    kind;
		logic [OFFSET_BITS-1:0]   record_offset;
		logic [KEY_BITS-1:0]      key_length;
		logic [LENGTH_BITS-1:0]   data_length;
		logic                     pair_flag;
		logic [COUNT_BITS-1:0]    record_count;
		logic [1:0]               error_code;
		logic                     final_result;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

FILE: rtl/kvw_front.sv
// ----------------------------------------------------------------------------
// kvw_front
// Byte parser: takes one message byte per cycle unless the queue is full,
// tracks record fields and sends descriptors and closing status to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvw_front import kvw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    data_byte,
	input  logic          end_of_message,
	input  queue_status_t qstat,
	output logic          wr_en,
	output result_t       wr_data
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_KEYLEN,
		PH_KEY,
		PH_TERM,
		PH_BODY,
		PH_ERROR
	} phase_t;

	phase_t                 phase_q,  phase_n;
	logic [CNT_BITS-1:0]    cnt_q,    cnt_n;
	logic [LENGTH_BITS-1:0] len_q,    len_n;
	logic [KEY_BITS-1:0]    key_q,    key_n;
	logic                   flag_q,   flag_n;
	logic [OFFSET_BITS-1:0] start_q,  start_n;
	logic [OFFSET_BITS-1:0] pos_q,    pos_n;
	logic [COUNT_BITS-1:0]  good_q,   good_n;
	logic [1:0]             err_q,    err_n;

	logic                   accept;
	logic                   produce;
	result_t                res;
	logic [CNT_BITS-1:0]    cnt_inc;
	logic [LENGTH_BITS-1:0] dlen;
	logic                   msg_ok;

	assign accept  = push && !qstat.full;
	assign cnt_inc = cnt_q + CNT_BITS'(1);
	assign dlen    = len_q - LENGTH_BITS'(key_q) - LENGTH_BITS'(MIN_OVERHEAD);

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		key_n   = key_q;
		flag_n  = flag_q;
		start_n = start_q;
		good_n  = good_q;
		err_n   = err_q;
		produce = 1'b0;
		res     = '0;
		msg_ok  = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				if (cnt_q == '0) begin
					start_n = pos_q;
				end
				len_n = {len_q[LENGTH_BITS-9:0], data_byte};
				if (cnt_q == CNT_BITS'(FLAG_BYTE)) begin
					flag_n = data_byte[FLAG_POS];
				end
				cnt_n = cnt_inc;
				if (cnt_inc >= CNT_BITS'(HDR_BYTES)) begin
					cnt_n   = '0;
					key_n   = '0;
					phase_n = PH_KEYLEN;
				end
			end
			PH_KEYLEN: begin
				key_n = {key_q[KEY_BITS-9:0], data_byte};
				cnt_n = cnt_inc;
				if (cnt_inc >= CNT_BITS'(KEYLEN_BYTES)) begin
					cnt_n = '0;
					if (CMP_BITS'(len_q) < CMP_BITS'(key_n) + CMP_BITS'(MIN_OVERHEAD)) begin
						if (err_q == ERR_NONE) begin
							err_n = ERR_SHORT;
						end
						phase_n = PH_ERROR;
					end else if (key_n == '0) begin
						phase_n = PH_TERM;
					end else begin
						phase_n = PH_KEY;
					end
				end
			end
			PH_KEY: begin
				cnt_n = cnt_inc;
				if (cnt_inc == CNT_BITS'(key_q)) begin
					cnt_n   = '0;
					phase_n = PH_TERM;
				end
			end
			PH_TERM: begin
				if (data_byte != 8'd0) begin
					if (err_q == ERR_NONE) begin
						err_n = ERR_TERM;
					end
					phase_n = PH_ERROR;
				end else begin
					produce           = 1'b1;
					res.kind          = KIND_DESC;
					res.record_offset = start_q;
					res.key_length    = key_q;
					res.data_length   = dlen;
					res.pair_flag     = flag_q;
					res.record_count  = good_q;
					len_n             = dlen + LENGTH_BITS'(1);
					phase_n           = PH_BODY;
				end
			end
			PH_BODY: begin
				len_n = len_q - LENGTH_BITS'(1);
				if (len_q == LENGTH_BITS'(1)) begin
					if (good_q != {COUNT_BITS{1'b1}}) begin
						good_n = good_q + COUNT_BITS'(1);
					end
					phase_n = PH_HEADER;
					cnt_n   = '0;
				end
			end
			default: begin
			end
		endcase

		pos_n = pos_q + OFFSET_BITS'(1);

		if (end_of_message) begin
			msg_ok           = (phase_n == PH_HEADER) && (cnt_n == '0) && (err_n == ERR_NONE);
			produce          = 1'b1;
			res              = '0;
			res.kind         = msg_ok ? KIND_OK : KIND_ERR;
			res.error_code   = msg_ok ? ERR_NONE : ((err_n != ERR_NONE) ? err_n : ERR_OVER);
			res.record_count = good_n;
			res.final_result = 1'b1;
			phase_n          = PH_HEADER;
			cnt_n            = '0;
			len_n            = '0;
			key_n            = '0;
			flag_n           = 1'b0;
			start_n          = '0;
			pos_n            = '0;
			good_n           = '0;
			err_n            = ERR_NONE;
		end
	end

	assign wr_en   = accept && produce;
	assign wr_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			cnt_q   <= '0;
			len_q   <= '0;
			key_q   <= '0;
			flag_q  <= 1'b0;
			start_q <= '0;
			pos_q   <= '0;
			good_q  <= '0;
			err_q   <= ERR_NONE;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			key_q   <= key_n;
			flag_q  <= flag_n;
			start_q <= start_n;
			pos_q   <= pos_n;
			good_q  <= good_n;
			err_q   <= err_n;
		end
	end

endmodule

FILE: rtl/kvw_queue.sv
// ----------------------------------------------------------------------------
// kvw_queue
// Short result queue between the parser and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvw_queue import kvw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  result_t       wr_data,
	input  logic          rd_en,
	output result_t       rd_data,
	output queue_status_t qstat
);

	result_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q;
	logic [QPTR_BITS-1:0] rptr_q;
	logic [QPTR_BITS:0]   count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign qstat.full  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_wr       = wr_en && !qstat.full;
	assign do_rd       = rd_en && !qstat.empty;
	assign rd_data     = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + QPTR_BITS'(1);
			end
			if (do_rd) begin
				rptr_q <= rptr_q + QPTR_BITS'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (QPTR_BITS+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_BITS+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/kv_record_stream_walker_top.sv
// ----------------------------------------------------------------------------
// kv_record_stream_walker_top
// Key/value record walker: one message byte in, record descriptors and a
// closing status per message out.
// ----------------------------------------------------------------------------
// The walker takes one byte per clock while full is low; every byte is
// parsed in the cycle it is accepted, and a descriptor or closing status it
// causes is written into the result queue and reaches the result ports once all
// results ahead of it are popped. Results wait in a four-entry queue, so the
// input keeps running while the consumer stalls; full rises only once four
// results are waiting, independent of pop in the same cycle. A closing status
// (final_result high) ends each message and the walker starts the next one from offset zero.
`timescale 1ns / 1ps

`include "kv_record_stream_walker_top_macros.svh"

module kv_record_stream_walker_top import kvw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             data_byte,
	input  logic                   end_of_message,
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             kind,
	output logic [OFFSET_BITS-1:0] record_offset,
	output logic [KEY_BITS-1:0]    key_length,
	output logic [LENGTH_BITS-1:0] data_length,
	output logic                   pair_flag,
	output logic [COUNT_BITS-1:0]  record_count,
	output logic [1:0]             error_code,
	output logic                   final_result
);

	queue_status_t qstat;
	logic          wr_en;
	result_t       wr_data;
	result_t       rd_data;

	kvw_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.qstat          (qstat),
		.wr_en          (wr_en),
		.wr_data        (wr_data)
	);

	kvw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (pop),
		.rd_data (rd_data),
		.qstat   (qstat)
	);

	assign full          = qstat.full;
	assign empty         = qstat.empty;
	assign kind          = rd_data.kind;
	assign record_offset = rd_data.record_offset;
	assign key_length    = rd_data.key_length;
	assign data_length   = rd_data.data_length;
	assign pair_flag     = rd_data.pair_flag;
	assign record_count  = rd_data.record_count;
	assign error_code    = rd_data.error_code;
	assign final_result  = rd_data.final_result;

	`KVW_ASSERT_IMPL(a_desc_clean, !empty && kind == KIND_DESC, !final_result && error_code == ERR_NONE, "descriptor carries status fields")
	`KVW_ASSERT_IMPL(a_final_kind, !empty && final_result, kind == KIND_OK || kind == KIND_ERR, "closing status with descriptor kind")
	`KVW_ASSERT_IMPL(a_err_code, !empty && kind == KIND_ERR, error_code != ERR_NONE, "error status without error code")
	`KVW_ASSERT_NEXT(a_eom_result, push && !full && end_of_message, !empty, "message end produced no result")

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key/value record walker. Messages of records
// (well-formed, truncated, malformed and pure noise) are streamed in byte by
// byte under random idling on both sides. A behavioral walker predicts each
// descriptor and closing status, and every popped result is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import kvw_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;

	localparam logic [2:0] WALK_HEADER = 3'd0;
	localparam logic [2:0] WALK_KEYLEN = 3'd1;
	localparam logic [2:0] WALK_KEY    = 3'd2;
	localparam logic [2:0] WALK_TERM   = 3'd3;
	localparam logic [2:0] WALK_BODY   = 3'd4;
	localparam logic [2:0] WALK_ERROR  = 3'd5;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	logic [7:0]             data_byte = 8'h00;
	logic                   end_of_message = 1'b0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic [1:0]             kind;
	logic [OFFSET_BITS-1:0] record_offset;
	logic [KEY_BITS-1:0]    key_length;
	logic [LENGTH_BITS-1:0] data_length;
	logic                   pair_flag;
	logic [COUNT_BITS-1:0]  record_count;
	logic [1:0]             error_code;
	logic                   final_result;

	// walker model state
	logic [2:0]             walk_phase;
	logic [15:0]            field_cnt;
	logic [LENGTH_BITS-1:0] rec_len;
	logic [KEY_BITS-1:0]    cur_klen;
	logic                   cur_flag;
	logic [OFFSET_BITS-1:0] rec_start;
	logic [OFFSET_BITS-1:0] msg_pos;
	logic [COUNT_BITS-1:0]  good_cnt;
	logic [1:0]             first_err;

	result_t     expected_results[$];
	logic [7:0]  msg_bytes[$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_left = 0;
	int          error_count = 0;
	int          items_sent = 0;
	int unsigned cycle_count = 0;

	kv_record_stream_walker_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.empty          (empty),
		.pop            (pop),
		.kind           (kind),
		.record_offset  (record_offset),
		.key_length     (key_length),
		.data_length    (data_length),
		.pair_flag      (pair_flag),
		.record_count   (record_count),
		.error_code     (error_code),
		.final_result   (final_result)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random pops, or a long hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task report_mismatch(input string msg);
		if (error_count < 50)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, kind %0d", kind));
			end else begin
				want = expected_results.pop_front();
				if (kind != want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
				if (record_offset != want.record_offset)
					report_mismatch($sformatf("record_offset %0h, want %0h",
						record_offset, want.record_offset));
				if (key_length != want.key_length)
					report_mismatch($sformatf("key_length %0h, want %0h",
						key_length, want.key_length));
				if (data_length != want.data_length)
					report_mismatch($sformatf("data_length %0h, want %0h",
						data_length, want.data_length));
				if (pair_flag != want.pair_flag)
					report_mismatch($sformatf("pair_flag %0b, want %0b",
						pair_flag, want.pair_flag));
				if (record_count != want.record_count)
					report_mismatch($sformatf("record_count %0d, want %0d",
						record_count, want.record_count));
				if (error_code != want.error_code)
					report_mismatch($sformatf("error_code %0d, want %0d",
						error_code, want.error_code));
				if (final_result != want.final_result)
					report_mismatch($sformatf("final_result %0b, want %0b",
						final_result, want.final_result));
			end
		end
	end

	task reset_walk();
		walk_phase = WALK_HEADER;
		field_cnt  = '0;
		rec_len    = '0;
		cur_klen   = '0;
		cur_flag   = 1'b0;
		rec_start  = '0;
		msg_pos    = '0;
		good_cnt   = '0;
		first_err  = ERR_NONE;
	endtask

	task flag_error(input logic [1:0] code);
		if (first_err == ERR_NONE)
			first_err = code;
		walk_phase = WALK_ERROR;
	endtask

	// advance the walker model by one accepted byte
	task walk_byte(input logic [7:0] b, input logic eom);
		result_t                res;
		logic                   emit;
		int                     lsb;
		logic [LENGTH_BITS-1:0] dlen;
		res  = '0;
		emit = 1'b0;
		lsb  = 24 - 8 * int'(field_cnt[1:0]);
		case (walk_phase)
		WALK_HEADER: begin
			if (field_cnt == 0)
				rec_start = msg_pos;
			rec_len = (rec_len << 8) | LENGTH_BITS'(b);
			if (FLAG_BIT >= lsb && FLAG_BIT < lsb + 8)
				cur_flag = b[FLAG_BIT - lsb];
			field_cnt = field_cnt + 16'd1;
			if (field_cnt >= HDR_BYTES) begin
				field_cnt  = '0;
				cur_klen   = '0;
				walk_phase = WALK_KEYLEN;
			end
		end
		WALK_KEYLEN: begin
			cur_klen  = {cur_klen[7:0], b};
			field_cnt = field_cnt + 16'd1;
			if (field_cnt >= KEYLEN_BYTES) begin
				field_cnt = '0;
				if (int'(rec_len) < int'(cur_klen) + MIN_OVERHEAD)
					flag_error(ERR_SHORT);
				else
					walk_phase = (cur_klen == 0) ? WALK_TERM : WALK_KEY;
			end
		end
		WALK_KEY: begin
			field_cnt = field_cnt + 16'd1;
			if (field_cnt == cur_klen) begin
				field_cnt  = '0;
				walk_phase = WALK_TERM;
			end
		end
		WALK_TERM: begin
			if (b != 8'h00) begin
				flag_error(ERR_TERM);
			end else begin
				dlen               = rec_len - LENGTH_BITS'(cur_klen)
					- LENGTH_BITS'(MIN_OVERHEAD);
				res.kind           = KIND_DESC;
				res.record_offset  = rec_start;
				res.key_length     = cur_klen;
				res.data_length    = dlen;
				res.pair_flag      = cur_flag;
				res.record_count   = good_cnt;
				emit               = 1'b1;
				rec_len            = dlen + LENGTH_BITS'(1);
				walk_phase         = WALK_BODY;
			end
		end
		WALK_BODY: begin
			rec_len = rec_len - LENGTH_BITS'(1);
			if (rec_len == 0) begin
				if (good_cnt != '1)
					good_cnt = good_cnt + COUNT_BITS'(1);
				walk_phase = WALK_HEADER;
				field_cnt  = '0;
			end
		end
		default: ;
		endcase
		msg_pos = msg_pos + OFFSET_BITS'(1);
		if (eom) begin
			res = '0;
			if (walk_phase == WALK_HEADER && field_cnt == 0 && first_err == ERR_NONE) begin
				res.kind = KIND_OK;
			end else begin
				res.kind       = KIND_ERR;
				res.error_code = (first_err != ERR_NONE) ? first_err : ERR_OVER;
			end
			res.record_count = good_cnt;
			res.final_result = 1'b1;
			emit             = 1'b1;
			reset_walk();
		end
		if (emit)
			expected_results.push_back(res);
	endtask

	// called just after a falling edge; returns just after a falling edge
	task send_byte(input logic [7:0] b, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push           <= 1'b1;
		data_byte      <= b;
		end_of_message <= eom;
		do @(posedge clk); while (full);
		walk_byte(b, eom);
		items_sent++;
		@(negedge clk);
	endtask

	task send_message();
		if (msg_bytes.size() == 0)
			msg_bytes.push_back(8'($urandom_range(255)));
		for (int i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		msg_bytes.delete();
	endtask

	task add_bytes(input int n);
		repeat (n) msg_bytes.push_back(8'($urandom_range(255)));
	endtask

	task add_head(input logic [31:0] word, input logic [15:0] klen);
		msg_bytes.push_back(word[31:24]);
		msg_bytes.push_back(word[23:16]);
		msg_bytes.push_back(word[15:8]);
		msg_bytes.push_back(word[7:0]);
		msg_bytes.push_back(klen[15:8]);
		msg_bytes.push_back(klen[7:0]);
	endtask

	// header bits outside the length field and the flag carry random junk
	task add_record(input int rlen, input int klen, input logic flag,
			input logic [7:0] term, input int dlen);
		logic [31:0] word;
		word                    = $urandom;
		word[LENGTH_BITS-1:0]   = LENGTH_BITS'(rlen);
		word[FLAG_BIT]          = flag;
		add_head(word, 16'(klen));
		add_bytes(klen);
		msg_bytes.push_back(term);
		add_bytes(dlen);
		add_bytes(1);
	endtask

	task add_good_record(input int klen, input int dlen);
		add_record(klen + MIN_OVERHEAD + dlen, klen, 1'($urandom_range(1)), 8'h00, dlen);
	endtask

	task test_well_formed();
		add_good_record(3, 2);
		send_message();
		add_good_record(0, 0);
		add_good_record(1, 0);
		add_good_record(0, 4);
		send_message();
	endtask

	task test_malformed();
		// record length one short of key length plus overhead
		add_good_record(1, 0);
		add_record(1 + MIN_OVERHEAD - 1, 1, 1'b1, 8'h00, 0);
		send_message();
		// nonzero terminator, then a good record that must be ignored
		add_record(2 + MIN_OVERHEAD, 2, 1'b0, 8'h80, 0);
		add_good_record(1, 1);
		send_message();
		// message ends inside the data
		add_good_record(0, 1);
		add_good_record(2, 3);
		repeat (2) void'(msg_bytes.pop_back());
		send_message();
		// terminator is the final byte: closing status only
		add_good_record(2, 3);
		repeat (4) void'(msg_bytes.pop_back());
		send_message();
		// ends inside the header
		add_good_record(0, 0);
		add_bytes(2);
		send_message();
		// one-byte message
		add_bytes(1);
		send_message();
	endtask

	task test_field_extremes();
		// all-ones header and key length, cut inside the key
		add_head(32'hFFFF_FFFF, 16'hFFFF);
		msg_bytes.push_back(8'hFF);
		msg_bytes.push_back(8'h00);
		send_message();
		// all-zero header and key length
		add_head(32'h0000_0000, 16'h0000);
		msg_bytes.push_back(8'h00);
		send_message();
		add_record(MIN_OVERHEAD, 0, 1'b1, 8'h00, 0);
		msg_bytes[msg_bytes.size() - 1] = 8'hFF;
		send_message();
	endtask

	task add_random_record();
		int klen;
		int dlen;
		klen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
		dlen = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(8);
		add_good_record(klen, dlen);
	endtask

	task build_random_message();
		int nrec;
		int bad;
		int klen;
		int cut;
		nrec = $urandom_range(1, 5);
		if ($urandom_range(99) < 70) begin
			repeat (nrec) add_random_record();
			return;
		end
		bad = $urandom_range(nrec - 1);
		case ($urandom_range(4))
		0: begin
			for (int i = 0; i < nrec; i++) begin
				klen = $urandom_range(5);
				if (i == bad)
					add_record(klen + MIN_OVERHEAD, klen, 1'($urandom_range(1)),
						8'($urandom_range(1, 255)), 0);
				else
					add_random_record();
			end
		end
		1: begin
			for (int i = 0; i < nrec; i++) begin
				klen = $urandom_range(5);
				if (i == bad)
					add_record($urandom_range(klen + MIN_OVERHEAD - 1), klen,
						1'($urandom_range(1)), 8'h00, 0);
				else
					add_random_record();
			end
		end
		2: begin
			repeat (nrec) add_random_record();
			cut = $urandom_range(1, msg_bytes.size() - 1);
			repeat (cut) void'(msg_bytes.pop_back());
		end
		3: begin
			repeat (nrec) add_random_record();
			add_bytes($urandom_range(1, 6));
		end
		default: add_bytes($urandom_range(1, 12));
		endcase
	endtask

	task test_random_messages(input int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			build_random_message();
			send_message();
		end
	endtask

	// receiver holds off while short records keep producing descriptors
	task test_full_stall();
		push <= 1'b0;
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		repeat (40) add_good_record(0, 0);
		send_message();
	endtask

	initial begin
		reset_walk();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_well_formed();
		test_malformed();
		test_field_extremes();

		send_idle_pct = 33;
		recv_idle_pct = 67;
		test_random_messages(600);
		send_idle_pct = 67;
		recv_idle_pct = 33;
		test_random_messages(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_messages(500);
		test_full_stall();

		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
